>>> sv/dds_pkg.sv
package dds_pkg;

   localparam logic [2:0] OP_SET_FREQ  = 3'd0;
   localparam logic [2:0] OP_SET_PHASE = 3'd1;
   localparam logic [2:0] OP_CONTROL   = 3'd2;
   localparam logic [2:0] OP_POWER     = 3'd3;
   localparam logic [2:0] OP_RESET_BIT = 3'd4;
   localparam logic [2:0] OP_WAVEFORM  = 3'd5;
   localparam logic [2:0] OP_BANK      = 3'd6;

   localparam logic [1:0] ARG_0 = 2'd0;
   localparam logic [1:0] ARG_1 = 2'd1;
   localparam logic [1:0] ARG_2 = 2'd2;

   localparam logic [31:0] MCLK_RESET   = 32'd24000000;
   localparam logic [13:0] CTRL_RESET   = 14'h2000;
   localparam logic [27:0] TW_MAX       = 28'hFFF_FFFF;
   localparam logic [15:0] FREQ_PRE_B0  = 16'h4000;
   localparam logic [15:0] FREQ_PRE_B1  = 16'h8000;
   localparam logic [15:0] PHASE_PRE_B0 = 16'hC000;
   localparam logic [15:0] PHASE_PRE_B1 = 16'hD000;
   localparam logic [13:0] PD_MASK      = 14'h00C0;
   localparam logic [13:0] RESET_MASK   = 14'h0100;
   localparam logic [13:0] BANK_MASK    = 14'h0C00;
   localparam logic [13:0] WAVE_CLR_ALL = 14'h3FDD;
   localparam logic [13:0] WAVE_CLR_OPB = 14'h3FDF;
   localparam logic [13:0] WAVE_CLR_TRI = 14'h3FFD;
   localparam logic [13:0] WAVE_TRI     = 14'h0002;
   localparam logic [13:0] WAVE_SQUARE  = 14'h0028;
   localparam logic [15:0] PHASE_LIMIT  = 16'd4096;
   localparam logic [11:0] PHASE_MAX    = 12'd4095;

   // one quotient bit per step: 32 frequency bits followed by 28 zeros
   localparam logic [5:0] DIV_LAST = 6'd59;

   typedef struct packed {
      logic [2:0]         operation;
      logic [31:0]        frequency_hz;
      logic signed [15:0] phase_value;
      logic [15:0]        control_value;
      logic [1:0]         small_argument;
   } req_type;

   typedef struct packed {
      logic [15:0] command_word;
      logic        last_word;
      logic [31:0] stored_frequency;
      logic [11:0] stored_phase;
      logic [13:0] control_shadow;
   } rsp_type;

   typedef struct packed {
      logic load_freq;
      logic exec_single;
      logic div_step;
      logic round;
      logic emit_low;
      logic emit_high;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic freq_trivial;
   } status_type;

endpackage

>>> sv/dds_datapath.sv
module dds_datapath (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [31:0]     csr_wr_data,
   input  dds_pkg::req_type req_data,
   input  dds_pkg::cmd_type cmd,
   output dds_pkg::status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dds_pkg::rsp_type rsp_data
);
   import dds_pkg::*;

   logic [31:0] mclk_ff, mclk_in;
   logic [13:0] ctrl_ff, ctrl_in;
   logic        bank_ff, bank_in;
   logic [31:0] freq_ff, freq_in;
   logic [11:0] phase_ff, phase_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [28:0] quot_ff, quot_in;
   logic [27:0] tw_ff, tw_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [32:0] rem_shift;
   logic        rem_ge;
   logic [28:0] tw_round;
   logic        round_up;
   logic [13:0] ctrl_new;
   logic        bank_new;
   logic [11:0] phase_new;
   logic [15:0] freq_pre;
   logic        trivial;

   assign trivial   = (req_data.frequency_hz == 32'd0) || (mclk_ff == 32'd0)
                      || (req_data.frequency_hz > mclk_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.freq_trivial = trivial;

   assign rem_shift = {rem_ff, dvd_ff[31]};
   assign rem_ge    = rem_shift >= {1'b0, mclk_ff};
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, mclk_ff};
   assign tw_round  = quot_ff + {28'd0, round_up};
   assign freq_pre  = bank_ff ? FREQ_PRE_B1 : FREQ_PRE_B0;

   // clamp phase to 0..4095
   always_comb begin
      if (req_data.phase_value[15]) begin
         phase_new = 12'd0;
      end else if (req_data.phase_value >= PHASE_LIMIT) begin
         phase_new = PHASE_MAX;
      end else begin
         phase_new = req_data.phase_value[11:0];
      end
   end

   // shadow control word edits; unknown arguments leave it as it was
   always_comb begin
      ctrl_new = ctrl_ff;
      bank_new = bank_ff;
      unique case (req_data.operation)
         OP_CONTROL: begin
            ctrl_new = req_data.control_value[13:0];
         end
         OP_POWER: begin
            ctrl_new = (ctrl_ff & ~PD_MASK) | {6'd0, req_data.small_argument, 6'd0};
         end
         OP_RESET_BIT: begin
            if (req_data.small_argument == ARG_0) begin
               ctrl_new = ctrl_ff & ~RESET_MASK;
            end else if (req_data.small_argument == ARG_1) begin
               ctrl_new = ctrl_ff | RESET_MASK;
            end
         end
         OP_WAVEFORM: begin
            priority if (req_data.small_argument == ARG_0) begin
               ctrl_new = ctrl_ff & WAVE_CLR_ALL;
            end else if (req_data.small_argument == ARG_1) begin
               ctrl_new = (ctrl_ff & WAVE_CLR_OPB) | WAVE_TRI;
            end else if (req_data.small_argument == ARG_2) begin
               ctrl_new = (ctrl_ff & WAVE_CLR_TRI) | WAVE_SQUARE;
            end else begin
               ctrl_new = ctrl_ff;
            end
         end
         OP_BANK: begin
            if (req_data.small_argument == ARG_0) begin
               ctrl_new = ctrl_ff & ~BANK_MASK;
               bank_new = 1'b0;
            end else if (req_data.small_argument == ARG_1) begin
               ctrl_new = ctrl_ff | BANK_MASK;
               bank_new = 1'b1;
            end
         end
         default: begin
            ctrl_new = ctrl_ff;
         end
      endcase
   end

   always_comb begin
      mclk_in      = csr_wr_en ? csr_wr_data : mclk_ff;
      ctrl_in      = ctrl_ff;
      bank_in      = bank_ff;
      freq_in      = freq_ff;
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quot_in      = quot_ff;
      tw_in        = tw_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load_freq) begin
         rem_in  = 32'd0;
         dvd_in  = req_data.frequency_hz;
         quot_in = 29'd0;
         if (req_data.frequency_hz == 32'd0) begin
            freq_in = 32'd0;
            tw_in   = 28'd0;
         end else if (trivial) begin
            freq_in = {1'b0, mclk_ff[31:1]};
            tw_in   = TW_MAX;
         end else begin
            freq_in = req_data.frequency_hz;
         end
      end

      if (cmd.div_step) begin
         rem_in  = rem_ge ? 32'(rem_shift - {1'b0, mclk_ff}) : rem_shift[31:0];
         dvd_in  = {dvd_ff[30:0], 1'b0};
         quot_in = {quot_ff[27:0], rem_ge};
      end

      if (cmd.round) begin
         tw_in = tw_round[28] ? TW_MAX : tw_round[27:0];
      end

      if (cmd.emit_low || cmd.emit_high) begin
         rsp_valid_in            = 1'b1;
         rsp_in.command_word     = freq_pre | {2'd0, cmd.emit_high ? tw_ff[27:14] : tw_ff[13:0]};
         rsp_in.last_word        = cmd.emit_high;
         rsp_in.stored_frequency = freq_ff;
         rsp_in.stored_phase     = phase_ff;
         rsp_in.control_shadow   = ctrl_ff;
      end

      if (cmd.exec_single) begin
         rsp_valid_in            = 1'b1;
         rsp_in.last_word        = 1'b1;
         rsp_in.stored_frequency = freq_ff;
         if (req_data.operation == OP_SET_PHASE) begin
            phase_in               = phase_new;
            rsp_in.command_word    = (bank_ff ? PHASE_PRE_B1 : PHASE_PRE_B0) | {4'd0, phase_new};
            rsp_in.stored_phase    = phase_new;
            rsp_in.control_shadow  = ctrl_ff;
         end else begin
            ctrl_in                = ctrl_new;
            bank_in                = bank_new;
            rsp_in.command_word    = {2'd0, ctrl_new};
            rsp_in.stored_phase    = phase_ff;
            rsp_in.control_shadow  = ctrl_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mclk_ff      <= MCLK_RESET;
         ctrl_ff      <= CTRL_RESET;
         bank_ff      <= 1'b0;
         freq_ff      <= 32'd0;
         phase_ff     <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mclk_ff      <= mclk_in;
         ctrl_ff      <= ctrl_in;
         bank_ff      <= bank_in;
         freq_ff      <= freq_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      tw_ff   <= tw_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/dds_controller.sv
module dds_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          operation,
   input  dds_pkg::status_type status,
   output dds_pkg::cmd_type    cmd
);
   import dds_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DIVIDE    = 5'b00010,
      ST_ROUND     = 5'b00100,
      ST_EMIT_LOW  = 5'b01000,
      ST_EMIT_HIGH = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = 6'd0;
            if (accept) begin
               if (operation == OP_SET_FREQ) begin
                  cmd.load_freq = 1'b1;
                  state_in      = status.freq_trivial ? ST_EMIT_LOW : ST_DIVIDE;
               end else if (operation <= OP_BANK) begin
                  cmd.exec_single = 1'b1;
               end
               // operation 7: drop the item
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 6'd1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_EMIT_LOW;
         end
         ST_EMIT_LOW: begin
            if (status.out_free) begin
               cmd.emit_low = 1'b1;
               state_in     = ST_EMIT_HIGH;
            end
         end
         ST_EMIT_HIGH: begin
            if (status.out_free) begin
               cmd.emit_high = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 6'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> sv/dds_command_word_generator_top.sv
// Set-frequency: the restoring divider in the datapath (60 steps, one quotient bit
// each) then a rounding step and two output words; a zero or out-of-range frequency
// skips the divider and the rounding. Operation 7 is dropped. Other commands: one word,
// loaded into the output register at accept; 1 per cycle while the output is not stalled.
// Synchronous active-high reset: control word 0x2000, bank 0, stored frequency and
// phase zero, master clock 24000000, output register empty.
module dds_command_word_generator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  dds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dds_pkg::rsp_type rsp_data
);
   import dds_pkg::*;

   cmd_type    cmd;
   status_type status;

   dds_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .operation (req_data.operation),
      .status    (status),
      .cmd       (cmd)
   );

   dds_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

>>> verif/tb_dds_command_word_generator_top.sv
`timescale 1ns / 100ps

module tb_dds_command_word_generator_top;
   import dds_pkg::*;

   localparam logic [2:0] OP_NONE = 3'd7;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   dds_command_word_generator_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   always #4 clock = ~clock;

   // shadow of the block state
   logic [31:0] mclk_cfg = MCLK_RESET;
   logic [13:0] ctrl_sh = CTRL_RESET;
   logic        bank_sel = 1'b0;
   logic [31:0] freq_rec = '0;
   logic [11:0] phase_rec = '0;

   req_type cmds_pending[$];
   rsp_type words_due[$];
   int      cmds_queued = 0;
   int      cmds_accepted = 0;
   int      words_checked = 0;
   int      fail_count = 0;
   int      clock_settings = 1;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      cycle_count = 0;

   function automatic logic [27:0] tuning_for(logic [31:0] f);
      logic [63:0] num;
      logic [63:0] quo;
      logic [63:0] rem;
      if (f == 32'd0) begin
         freq_rec = '0;
         return '0;
      end
      if (mclk_cfg == 32'd0 || f > mclk_cfg) begin
         freq_rec = mclk_cfg >> 1;
         return TW_MAX;
      end
      freq_rec = f;
      num = 64'(f) << 28;
      quo = num / 64'(mclk_cfg);
      rem = num % 64'(mclk_cfg);
      // round half up, then saturate
      if ((rem << 1) >= 64'(mclk_cfg)) quo = quo + 64'd1;
      if (quo > 64'(TW_MAX)) quo = 64'(TW_MAX);
      return quo[27:0];
   endfunction

   function automatic rsp_type make_word(logic [15:0] word, logic last);
      rsp_type r;
      r.command_word     = word;
      r.last_word        = last;
      r.stored_frequency = freq_rec;
      r.stored_phase     = phase_rec;
      r.control_shadow   = ctrl_sh;
      return r;
   endfunction

   function automatic void predict_words(req_type cmd);
      logic [27:0] tw;
      logic [15:0] pre;
      logic [15:0] raw;
      logic [13:0] c;
      c = ctrl_sh;
      case (cmd.operation)
         OP_SET_FREQ: begin
            tw = tuning_for(cmd.frequency_hz);
            pre = bank_sel ? FREQ_PRE_B1 : FREQ_PRE_B0;
            words_due.push_back(make_word({2'b00, tw[13:0]} | pre, 1'b0));
            words_due.push_back(make_word({2'b00, tw[27:14]} | pre, 1'b1));
         end
         OP_SET_PHASE: begin
            raw = cmd.phase_value;
            if (raw[15]) phase_rec = '0;
            else if (raw >= PHASE_LIMIT) phase_rec = PHASE_MAX;
            else phase_rec = raw[11:0];
            pre = bank_sel ? PHASE_PRE_B1 : PHASE_PRE_B0;
            words_due.push_back(make_word({4'h0, phase_rec} | pre, 1'b1));
         end
         OP_NONE: begin
         end
         default: begin
            case (cmd.operation)
               OP_CONTROL: c = cmd.control_value[13:0];
               OP_POWER: c = (c & ~PD_MASK) | {6'd0, cmd.small_argument, 6'd0};
               OP_RESET_BIT: begin
                  if (cmd.small_argument == ARG_0) c = c & ~RESET_MASK;
                  else if (cmd.small_argument == ARG_1) c = c | RESET_MASK;
               end
               OP_WAVEFORM: begin
                  if (cmd.small_argument == ARG_0) c = c & WAVE_CLR_ALL;
                  else if (cmd.small_argument == ARG_1) c = (c & WAVE_CLR_OPB) | WAVE_TRI;
                  else if (cmd.small_argument == ARG_2)
                     c = (c & WAVE_CLR_TRI) | WAVE_SQUARE;
               end
               default: begin
                  if (cmd.small_argument == ARG_0) begin
                     c = c & ~BANK_MASK;
                     bank_sel = 1'b0;
                  end else if (cmd.small_argument == ARG_1) begin
                     c = c | BANK_MASK;
                     bank_sel = 1'b1;
                  end
               end
            endcase
            ctrl_sh = c;
            words_due.push_back(make_word({2'b00, ctrl_sh}, 1'b1));
         end
      endcase
   endfunction

   // driver: present the next item, hold it until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_words(req_data);
            cmds_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (cmds_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= cmds_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected %h actual %h", $realtime, field, want, got);
      fail_count++;
   endtask

   // monitor: check each word against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (words_due.size() == 0) begin
               $display("%0t unexpected word: expected none actual %h", $realtime, rsp_data);
               fail_count++;
            end else begin
               want = words_due.pop_front();
               words_checked++;
               if (rsp_data.command_word !== want.command_word)
                  report_field("command_word", 32'(want.command_word),
                               32'(rsp_data.command_word));
               if (rsp_data.last_word !== want.last_word)
                  report_field("last_word", 32'(want.last_word), 32'(rsp_data.last_word));
               if (rsp_data.stored_frequency !== want.stored_frequency)
                  report_field("stored_frequency", want.stored_frequency,
                               rsp_data.stored_frequency);
               if (rsp_data.stored_phase !== want.stored_phase)
                  report_field("stored_phase", 32'(want.stored_phase),
                               32'(rsp_data.stored_phase));
               if (rsp_data.control_shadow !== want.control_shadow)
                  report_field("control_shadow", 32'(want.control_shadow),
                               32'(rsp_data.control_shadow));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d words outstanding", $realtime, words_due.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic push_cmd(logic [2:0] op, logic [31:0] f, logic [15:0] ph,
                           logic [15:0] cv, logic [1:0] arg);
      req_type c;
      c.operation      = op;
      c.frequency_hz   = f;
      c.phase_value    = ph;
      c.control_value  = cv;
      c.small_argument = arg;
      cmds_pending.push_back(c);
      cmds_queued++;
   endtask

   task automatic push_random(int count);
      req_type c;
      int pick;
      repeat (count) begin
         c.frequency_hz   = $urandom;
         c.phase_value    = 16'($urandom);
         c.control_value  = 16'($urandom);
         c.small_argument = 2'($urandom);
         pick = $urandom_range(99);
         if (pick < 30) c.operation = OP_SET_FREQ;
         else if (pick < 45) c.operation = OP_SET_PHASE;
         else if (pick < 97) c.operation = 3'($urandom_range(OP_BANK, OP_CONTROL));
         else c.operation = OP_NONE;
         if (c.operation == OP_SET_FREQ) begin
            // steer toward zero, the clock edge and the in-range band
            case ($urandom_range(5))
               0: c.frequency_hz = '0;
               1: c.frequency_hz = mclk_cfg;
               2: c.frequency_hz = mclk_cfg + 32'd1;
               3: c.frequency_hz = mclk_cfg - 32'd1;
               4: if (mclk_cfg != 0) c.frequency_hz = c.frequency_hz % mclk_cfg;
               default: ;
            endcase
         end
         if (c.operation == OP_SET_PHASE && $urandom_range(1))
            c.phase_value = 16'($urandom_range(4095));
         cmds_pending.push_back(c);
         cmds_queued++;
      end
   endtask

   task automatic drain();
      while (cmds_accepted != cmds_queued || words_due.size() != 0) @(posedge clock);
      // an unknown operation leaves nothing to wait for; give the block time anyway
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock(logic [31:0] value, int send_pct, int recv_pct);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      mclk_cfg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clock_settings++;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      logic [31:0] v;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset clock of 24 MHz
      push_cmd(OP_SET_FREQ, 32'd0, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'd1, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'd12000000, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'd24000000, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'd24000001, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'hFFFF_FFFF, '0, '0, ARG_0);
      push_cmd(OP_SET_PHASE, '0, 16'h8000, '0, ARG_0);
      push_cmd(OP_SET_PHASE, '0, 16'hFFFF, '0, ARG_0);
      push_cmd(OP_SET_PHASE, '0, 16'd4095, '0, ARG_0);
      push_cmd(OP_SET_PHASE, '0, 16'd4096, '0, ARG_0);
      push_cmd(OP_SET_PHASE, '0, 16'h7FFF, '0, ARG_0);
      push_cmd(OP_CONTROL, '0, '0, 16'hFFFF, ARG_0);
      push_cmd(OP_POWER, '0, '0, '0, 2'd3);
      push_cmd(OP_POWER, '0, '0, '0, ARG_1);
      push_cmd(OP_RESET_BIT, '0, '0, '0, ARG_1);
      push_cmd(OP_RESET_BIT, '0, '0, '0, ARG_2);
      push_cmd(OP_WAVEFORM, '0, '0, '0, ARG_2);
      push_cmd(OP_WAVEFORM, '0, '0, '0, ARG_1);
      push_cmd(OP_WAVEFORM, '0, '0, '0, 2'd3);
      push_cmd(OP_WAVEFORM, '0, '0, '0, ARG_0);
      push_cmd(OP_BANK, '0, '0, '0, ARG_1);
      push_cmd(OP_SET_FREQ, 32'd1000000, '0, '0, ARG_0);
      push_cmd(OP_SET_PHASE, '0, 16'd1234, '0, ARG_0);
      push_cmd(OP_BANK, '0, '0, '0, ARG_2);
      push_cmd(OP_BANK, '0, '0, '0, ARG_0);
      push_cmd(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 2'd3);
      push_cmd(OP_CONTROL, '0, '0, 16'h0000, ARG_0);
      push_random(55);
      drain();

      write_clock(32'd1, 0, 0);
      push_random(55);
      drain();

      write_clock(32'hFFFF_FFFF, 77, 0);
      push_random(65);
      drain();

      v = $urandom;
      if (v == 0) v = 32'd1;
      write_clock(v, 0, 77);
      push_random(65);
      drain();

      // a clock of 2^29 makes odd frequencies land exactly on one half
      write_clock(32'h2000_0000, 31, 31);
      push_cmd(OP_SET_FREQ, 32'd1, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'd3, '0, '0, ARG_0);
      push_random(55);
      drain();

      // zero clock: only a zero frequency stays in range
      write_clock(32'd0, 0, 0);
      push_cmd(OP_SET_FREQ, 32'd0, '0, '0, ARG_0);
      push_cmd(OP_SET_FREQ, 32'd5, '0, '0, ARG_0);
      push_random(10);
      drain();

      write_clock(MCLK_RESET, 31, 31);
      push_random(55);
      drain();

      v = $urandom;
      if (v == 0) v = 32'd1;
      write_clock(v, 77, 77);
      push_random(55);
      drain();

      $display("run covered %0d commands and %0d checked words", cmds_accepted, words_checked);
      $display("across %0d master clock settings, %0d mismatches", clock_settings, fail_count);
      if (fail_count == 0 && words_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
